// ===== rtl/core/bmc_pkg.sv =====
// Package: shared types, codes and helpers of the multi-click / long-press detector.
`timescale 1ns / 1ps

package bmc_pkg;

    localparam int KEY_W   = 2;
    localparam int EVENT_W = 3;
    localparam int CNT_W   = 8;
    localparam int CLICK_W = 4;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 8;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_CLICK_GAP  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LONG_PRESS = 1'd1;

    // Register reset values
    localparam logic [CNT_W-1:0] CLICK_GAP_RST  = 8'd20;
    localparam logic [CNT_W-1:0] LONG_PRESS_RST = 8'd100;

    // Event codes
    localparam logic [EVENT_W-1:0] EV_NONE   = 3'd0;
    localparam logic [EVENT_W-1:0] EV_SINGLE = 3'd1;
    localparam logic [EVENT_W-1:0] EV_QUINT  = 3'd5;
    localparam logic [EVENT_W-1:0] EV_LONG   = 3'd6;

    localparam logic [CLICK_W-1:0] CLICK_SAT = 4'd15;

    typedef struct packed {
        logic [CNT_W-1:0] click_gap_ticks;
        logic [CNT_W-1:0] long_press_ticks;
    } bmc_cfg_t;

    typedef struct packed {
        logic [EVENT_W-1:0] event_res;
        logic [KEY_W-1:0]   key_code;
    } bmc_res_t;

    function automatic logic [CNT_W-1:0] sat_inc8(input logic [CNT_W-1:0] v);
        return (v == {CNT_W{1'b1}}) ? v : v + 1'b1;
    endfunction

endpackage

// ===== rtl/core/bmc_if.sv =====
// Interfaces: key tick channel and event result channel.
`timescale 1ns / 1ps

interface bmc_key_if;
    logic                      valid;
    logic                      ready;
    logic [bmc_pkg::KEY_W-1:0] key_bits;

    modport source (output valid, output key_bits, input ready);
    modport sink   (input valid, input key_bits, output ready);
endinterface

interface bmc_res_if;
    logic                        valid;
    logic                        ready;
    logic [bmc_pkg::EVENT_W-1:0] event_res;
    logic [bmc_pkg::KEY_W-1:0]   key_code;

    modport source (output valid, output event_res, output key_code, input ready);
    modport sink   (input valid, input event_res, input key_code, output ready);
endinterface

// ===== rtl/core/bmc_core.sv =====
// Detector state machine: one state update per accepted tick item.
`timescale 1ns / 1ps

module bmc_core
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  bmc_pkg::bmc_cfg_t         cfg,
    input  logic                      accept,
    input  logic [bmc_pkg::KEY_W-1:0] key_bits,
    output bmc_pkg::bmc_res_t         res
);

    typedef enum logic [1:0] {
        PH_UP   = 2'd0,
        PH_DOWN = 2'd1,
        PH_HOLD = 2'd2,
        PH_LONG = 2'd3
    } phase_t;

    phase_t                         phase_reg, phase_next;
    logic [bmc_pkg::CNT_W-1:0]      hold_count_reg, hold_count_next;
    logic [bmc_pkg::CNT_W-1:0]      gap_count_reg, gap_count_next;
    logic                           gap_running_reg, gap_running_next;
    logic [bmc_pkg::CLICK_W-1:0]    click_count_reg, click_count_next;
    logic [bmc_pkg::KEY_W-1:0]      latched_key_reg, latched_key_next;
    logic [bmc_pkg::CNT_W-1:0]      gap_inc;
    logic                           run_end;
    logic                           pressed;
    logic [bmc_pkg::EVENT_W-1:0]    ev;

    always_comb
    begin
        pressed = |key_bits;
        gap_inc = gap_running_reg ? bmc_pkg::sat_inc8(gap_count_reg) : gap_count_reg;
        run_end = gap_inc > cfg.click_gap_ticks;
        ev      = bmc_pkg::EV_NONE;

        phase_next       = phase_reg;
        hold_count_next  = hold_count_reg;
        gap_count_next   = gap_inc;
        gap_running_next = gap_running_reg;
        click_count_next = click_count_reg;
        latched_key_next = latched_key_reg;

        // gap expired: close the click run, report 1..5 clicks
        if (run_end)
        begin
            if (click_count_reg >= 4'(bmc_pkg::EV_SINGLE)
                && click_count_reg <= 4'(bmc_pkg::EV_QUINT))
            begin
                ev = click_count_reg[bmc_pkg::EVENT_W-1:0];
            end
            gap_count_next   = '0;
            gap_running_next = 1'b0;
            click_count_next = '0;
        end

        unique case (phase_reg)
            PH_UP:
            begin
                if (pressed)
                begin
                    phase_next = PH_DOWN;
                end
            end
            PH_DOWN:
            begin
                if (pressed)
                begin
                    gap_running_next = 1'b0;
                    phase_next       = PH_HOLD;
                    latched_key_next = key_bits;
                end
                else
                begin
                    phase_next = PH_UP;
                end
            end
            PH_HOLD:
            begin
                hold_count_next = bmc_pkg::sat_inc8(hold_count_reg);
                if (!pressed)
                begin
                    hold_count_next  = '0;
                    gap_count_next   = '0;
                    gap_running_next = 1'b1;
                    if (click_count_next < bmc_pkg::CLICK_SAT)
                    begin
                        click_count_next = click_count_next + 1'b1;
                    end
                    phase_next = PH_UP;
                end
                // long press overrides any click result of this tick
                if (hold_count_next > cfg.long_press_ticks)
                begin
                    phase_next       = PH_LONG;
                    gap_count_next   = '0;
                    gap_running_next = 1'b0;
                    click_count_next = '0;
                    latched_key_next = key_bits;
                    ev               = bmc_pkg::EV_LONG;
                end
            end
            PH_LONG:
            begin
                hold_count_next = bmc_pkg::sat_inc8(hold_count_reg);
                if (!pressed)
                begin
                    hold_count_next = '0;
                    phase_next      = PH_UP;
                end
            end
            default:
            begin
                phase_next = PH_UP;
            end
        endcase

        res.event_res = ev;
        res.key_code  = latched_key_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= PH_UP;
            hold_count_reg  <= '0;
            gap_count_reg   <= '0;
            gap_running_reg <= 1'b0;
            click_count_reg <= '0;
            latched_key_reg <= '0;
        end
        else if (accept)
        begin
            phase_reg       <= phase_next;
            hold_count_reg  <= hold_count_next;
            gap_count_reg   <= gap_count_next;
            gap_running_reg <= gap_running_next;
            click_count_reg <= click_count_next;
            latched_key_reg <= latched_key_next;
        end
    end

endmodule

// ===== rtl/core/bmc_out.sv =====
// Result register with skid stage between the state machine and the result channel.
`timescale 1ns / 1ps

module bmc_out
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              accept,
    input  bmc_pkg::bmc_res_t res,
    output logic              ready,
    output logic              out_valid,
    input  logic              out_ready,
    output bmc_pkg::bmc_res_t out_res
);

    logic              out_valid_reg;
    bmc_pkg::bmc_res_t out_res_reg;
    logic              skid_valid_reg;
    bmc_pkg::bmc_res_t skid_res_reg;
    logic              out_free;

    assign out_free  = !out_valid_reg || out_ready;
    assign ready     = !skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_res   = out_res_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            if (skid_valid_reg)
            begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
            else
            begin
                out_valid_reg <= accept;
            end
        end
        else if (accept)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_free)
        begin
            out_res_reg <= skid_valid_reg ? skid_res_reg : res;
        end
        if (!out_free && accept)
        begin
            skid_res_reg <= res;
        end
    end

endmodule

// ===== rtl/core/button_multi_click_long_press_top.sv =====
// Top level: multi-click and long-press detector for two sampled keys.
`timescale 1ns / 1ps

// Usage
//   key_chan (sink): one item per scan tick carrying key_bits, the sampled
//   pressed levels of the two keys. res_chan (source): exactly one item per
//   tick: event_res (0 none, 1..5 single..quintuple click, 6 long press)
//   and key_code, the key bits latched at press confirmation and at long press.
//   cfg_we/cfg_index/cfg_data write click_gap_ticks (index 0) and
//   long_press_ticks (index 1); write only while no ticks are in flight.
// Result path: the result of an accepted tick is formed combinationally and
//   captured in the result register, or in the skid stage on a stall.
// Throughput: one tick per cycle unless stalled; the whole state update
//   is a single pass of compares and 8-bit increments ahead of the state registers.
// Stall: a result register plus a one-entry skid stage buffer results;
//   key_chan.ready drops only when both are full, and no item is lost.
// Reset: rst_n (async, active low) returns the machine to the up phase,
//   clears all counters and the latched key, empties both output stages, and
//   loads the register defaults (gap 20, long press 100 ticks).
module button_multi_click_long_press_top
(
    input  logic                           clk,
    input  logic                           rst_n,
    bmc_key_if.sink                        key_chan,
    bmc_res_if.source                      res_chan,
    input  logic                           cfg_we,
    input  logic [bmc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [bmc_pkg::CFG_DATA_W-1:0] cfg_data
);

    bmc_pkg::bmc_cfg_t cfg_reg;
    bmc_pkg::bmc_res_t core_res;
    bmc_pkg::bmc_res_t out_res;
    logic              in_ready;
    logic              accept;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.click_gap_ticks  <= bmc_pkg::CLICK_GAP_RST;
            cfg_reg.long_press_ticks <= bmc_pkg::LONG_PRESS_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                bmc_pkg::REG_CLICK_GAP:  cfg_reg.click_gap_ticks  <= cfg_data;
                bmc_pkg::REG_LONG_PRESS: cfg_reg.long_press_ticks <= cfg_data;
                default: ;
            endcase
        end
    end

    assign key_chan.ready = in_ready;
    assign accept         = key_chan.valid && in_ready;

    bmc_core u_core
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .accept   (accept),
        .key_bits (key_chan.key_bits),
        .res      (core_res)
    );

    bmc_out u_out
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .res       (core_res),
        .ready     (in_ready),
        .out_valid (res_chan.valid),
        .out_ready (res_chan.ready),
        .out_res   (out_res)
    );

    assign res_chan.event_res = out_res.event_res;
    assign res_chan.key_code  = out_res.key_code;

    // a long event always carries the key that was held
    a_long_has_key: assert property (@(posedge clk) disable iff (!rst_n)
        res_chan.valid && res_chan.event_res == bmc_pkg::EV_LONG
        |-> res_chan.key_code != '0)
        else $error("long press reported with empty key code");

    // input back-pressure only when results are waiting
    a_stall_has_result: assert property (@(posedge clk) disable iff (!rst_n)
        !key_chan.ready |-> res_chan.valid)
        else $error("input stalled with no result pending");

    // one result per tick: an accepted tick leaves res_chan.valid high in the next cycle
    a_tick_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        key_chan.valid && key_chan.ready |=> res_chan.valid)
        else $error("accepted tick produced no result");

endmodule
